FILE: src/slot_allocator_bump_free_list_assert.svh
// Assertion macros for the checker file of the slot allocator.
// Each macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef SLOT_ALLOCATOR_BUMP_FREE_LIST_ASSERT_SVH
`define SLOT_ALLOCATOR_BUMP_FREE_LIST_ASSERT_SVH

// Same-cycle implication.
`define SABFL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot allocator check failed");

// Next-cycle implication.
`define SABFL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot allocator check failed");

`endif

FILE: src/sabfl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sabfl_pkg
// Constants shared by the slot allocator files.
// ----------------------------------------------------------------------------
package sabfl_pkg;

    localparam int SLOT_W         = 8;
    localparam int COUNT_W        = 9;
    localparam int LINK_DEPTH_MAX = 1 << SLOT_W;
    localparam int MAX_SLOTS_DEF  = 256;

    localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = 9'd256;
    localparam logic [COUNT_W-1:0] COUNT_SAT      = '1;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 16;
    localparam int M_PAD_W   = M_TDATA_W - SLOT_W - 3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

endpackage

FILE: src/sabfl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sabfl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sabfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/slot_allocator_bump_free_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_allocator_bump_free_list
// Slot allocator: linked free list in RAM backed by a bump counter.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake           | payload
//  s_*      | in  | s_tvalid / s_tready | tuser: op; tdata: slot_index
//  m_*      | out | m_tvalid / m_tready | tdata: slot, ok, full_res, empty_res
//  cfg_*    | in  | cfg_valid/cfg_ready | cfg_data: slot_count
//
// An allocate served from the free list also passes through ST_POP: the next link
// is read from the link RAM before the head can move. Other requests stay in ST_IDLE.
// The result is registered and shows on m_* the cycle after acceptance; a new
// request is taken while that result is being drained.
// Reset clears the counters and the list length; the link RAM needs no clear.
// ----------------------------------------------------------------------------
module slot_allocator_bump_free_list
    import sabfl_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] slot_index
    input  logic [S_TUSER_W-1:0] s_tuser,   // [0] op
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] slot, [8] ok, [9] full_res,
                                            // [10] empty_res, [15:11] zero
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [COUNT_W-1:0]   cfg_data   // [8:0] slot_count
);

    localparam int LINK_DEPTH = (MAX_SLOTS < LINK_DEPTH_MAX) ? MAX_SLOTS : LINK_DEPTH_MAX;
    localparam int LINK_AW    = $clog2(LINK_DEPTH);
    localparam logic [COUNT_W-1:0] CAP_LIMIT = COUNT_W'(LINK_DEPTH);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_POP
    } state_t;

    state_t               state_reg;
    logic [COUNT_W-1:0]   slot_count_reg;
    logic [COUNT_W-1:0]   bump_reg, bump_next;
    logic [SLOT_W-1:0]    head_reg, head_next;
    logic [COUNT_W-1:0]   flen_reg, flen_next;
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic                 accept;
    logic                 op;
    logic [SLOT_W-1:0]    idx;
    logic [COUNT_W-1:0]   cap;
    logic [COUNT_W-1:0]   bump_dec;
    logic [SLOT_W-1:0]    res_slot;
    logic                 res_ok;
    logic                 res_full;
    logic                 res_empty;
    logic                 pop_go;
    logic                 link_wr;
    logic [SLOT_W-1:0]    link_rd_data;

    assign op       = s_tuser[0];
    assign idx      = s_tdata[SLOT_W-1:0];
    assign cap      = (slot_count_reg > CAP_LIMIT) ? CAP_LIMIT : slot_count_reg;
    assign bump_dec = bump_reg - 1'b1;

    assign s_tready  = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_comb
    begin
        bump_next = bump_reg;
        head_next = head_reg;
        flen_next = flen_reg;
        res_slot  = '0;
        res_ok    = 1'b0;
        pop_go    = 1'b0;
        link_wr   = 1'b0;
        if (op == OP_ALLOC)
        begin
            if (flen_reg != '0)
            begin
                // pop: head moves once the link read returns
                res_slot  = head_reg;
                flen_next = flen_reg - 1'b1;
                res_ok    = 1'b1;
                pop_go    = 1'b1;
            end
            else if (bump_reg < cap)
            begin
                res_slot  = bump_reg[SLOT_W-1:0];
                bump_next = bump_reg + 1'b1;
                res_ok    = 1'b1;
            end
        end
        else if ({1'b0, idx} < cap)
        begin
            res_ok = 1'b1;
            if ((bump_reg != '0) && ({1'b0, idx} == bump_dec))
            begin
                bump_next = bump_dec;
            end
            else
            begin
                link_wr   = 1'b1;
                head_next = idx;
                if (flen_reg != COUNT_SAT)
                begin
                    flen_next = flen_reg + 1'b1;
                end
            end
        end
        res_full      = (bump_next >= cap) && (flen_next == '0);
        res_empty     = (bump_next == flen_next);
        out_data_next = {{M_PAD_W{1'b0}}, res_empty, res_full, res_ok, res_slot};
    end

    sabfl_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (accept && link_wr),
        .wr_addr (idx[LINK_AW-1:0]),
        .wr_data (head_reg),
        .rd_en   (accept && pop_go),
        .rd_addr (head_reg[LINK_AW-1:0]),
        .rd_data (link_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slot_count_reg <= SLOT_COUNT_RST;
            bump_reg       <= '0;
            head_reg       <= '0;
            flen_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                slot_count_reg <= cfg_data;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= out_data_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        bump_reg <= bump_next;
                        head_reg <= head_next;
                        flen_reg <= flen_next;
                        if (pop_go)
                        begin
                            state_reg <= ST_POP;
                        end
                    end
                end
                ST_POP:
                begin
                    // link read has landed: advance the head
                    head_reg  <= link_rd_data;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: src/sabfl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sabfl_checker
// Port-level checks for the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "slot_allocator_bump_free_list_assert.svh"

module sabfl_checker
    import sabfl_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // hold a stalled result
    `SABFL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // every accepted request gives a result on the next cycle
    `SABFL_ASSERT_NEXT(a_result_follows, s_tvalid && s_tready, m_tvalid)
    // a failed request reports slot zero
    `SABFL_ASSERT_NOW(a_fail_slot_zero, m_tvalid && !m_tdata[SLOT_W], m_tdata[SLOT_W-1:0] == '0)
    // padding stays zero
    `SABFL_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[M_TDATA_W-1:SLOT_W+3] == '0)

endmodule

bind slot_allocator_bump_free_list sabfl_checker u_sabfl_checker (.*);
